### sv/miu_pkg.sv
package miu_pkg;

  // Modulus after reset, truncated to the data width where it is used.
  localparam int unsigned ModResetValue = 256;

  // Sequencer states, one-hot.
  typedef enum logic [5:0] {
    StIdle   = 6'b000001,
    StReduce = 6'b000010,
    StTest   = 6'b000100,
    StDiv    = 6'b001000,
    StUpd    = 6'b010000,
    StDone   = 6'b100000
  } state_e;

endpackage

### sv/miu_step.sv
// One step of the shared unit: a restoring division bit and, beside it,
// one Horner step of the quotient times coefficient product modulo m.
module miu_step #(
  parameter int unsigned DATA_WIDTH = 16
) (
  input  logic [DATA_WIDTH-1:0] rem_i,
  input  logic                  bit_i,
  input  logic [DATA_WIDTH-1:0] divisor_i,
  input  logic [DATA_WIDTH-1:0] acc_i,
  input  logic                  qbit_i,
  input  logic [DATA_WIDTH-1:0] mult_i,
  input  logic [DATA_WIDTH-1:0] mod_i,
  output logic [DATA_WIDTH-1:0] rem_o,
  output logic                  qbit_o,
  output logic [DATA_WIDTH-1:0] acc_o
);

  logic [DATA_WIDTH:0] shifted;
  logic [DATA_WIDTH:0] diff;
  logic [DATA_WIDTH:0] dbl;
  logic [DATA_WIDTH:0] dbl_red;
  logic [DATA_WIDTH:0] sum;
  logic [DATA_WIDTH:0] mod_ext;

  assign mod_ext = {1'b0, mod_i};

  // Division: bring in the next dividend bit and subtract if it fits.
  always_comb begin
    shifted = {rem_i, bit_i};
    diff    = shifted - {1'b0, divisor_i};
    qbit_o  = (shifted >= {1'b0, divisor_i});
    rem_o   = qbit_o ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
  end

  // Product: acc = (2 * acc + qbit * mult) mod m, with acc and mult below m.
  always_comb begin
    dbl     = {acc_i, 1'b0};
    dbl_red = (dbl >= mod_ext) ? (dbl - mod_ext) : dbl;
    sum     = dbl_red + (qbit_i ? {1'b0, mult_i} : '0);
    acc_o   = (sum >= mod_ext) ? sum[DATA_WIDTH-1:0] - mod_i : sum[DATA_WIDTH-1:0];
  end

endmodule

### sv/modular_inverse_unit.sv
// Channel   Direction  Signals                                  Moves per transfer
// ------    ---------  ---------------------------------------  ----------------------
// config    in         cfg_valid_i  cfg_ready_o  cfg_modulus_i  new modulus
// input     in         in_valid_i   in_ready_o   value_i        value to invert
// output    out        out_valid_o  out_ready_i  inverse_o,     inverse and flag
//                                                has_inverse_o
//
// Steps: the value is first reduced modulo m, then each Euclid round runs a
// test, a divide and an update step. A 16-bit item needs at most 22 rounds,
// all on the single division and modular multiply step unit. A modulus below
// two skips the search and goes straight to the done state.
// Reset puts the modulus at 256 and the sequencer idle with no result pending.
// Input and configuration are taken only while idle, and an offered
// configuration write holds the input off in that cycle. A finished result
// waits in the output register, and a new item may be taken while it waits.
module modular_inverse_unit #(
  parameter int unsigned DATA_WIDTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [DATA_WIDTH-1:0] cfg_modulus_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [DATA_WIDTH-1:0] value_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [DATA_WIDTH-1:0] inverse_o,
  output logic                  has_inverse_o
);

  import miu_pkg::*;

  localparam int unsigned CntWidth = $clog2(DATA_WIDTH + 1);
  localparam logic [DATA_WIDTH-1:0] ModReset = DATA_WIDTH'(ModResetValue);
  localparam logic [CntWidth-1:0] CntLastBit = CntWidth'(DATA_WIDTH - 1);
  localparam logic [CntWidth-1:0] CntFlush = CntWidth'(DATA_WIDTH);

  state_e state_q, state_d;

  logic [DATA_WIDTH-1:0] mod_q;
  logic [DATA_WIDTH-1:0] r0_q, r0_d, r1_q, r1_d;
  logic [DATA_WIDTH-1:0] t0_q, t0_d, t1_q, t1_d;
  logic [DATA_WIDTH-1:0] rem_q, rem_d, div_q, div_d;
  logic [DATA_WIDTH-1:0] acc_q, acc_d;
  logic                  qbit_q, qbit_d;
  logic [CntWidth-1:0]   cnt_q, cnt_d;
  logic [DATA_WIDTH-1:0] res_inv_q, res_inv_d;
  logic                  res_ok_q, res_ok_d;
  logic                  out_valid_q, out_valid_d;
  logic [DATA_WIDTH-1:0] inverse_q, inverse_d;
  logic                  has_inverse_q, has_inverse_d;

  logic [DATA_WIDTH-1:0] step_divisor;
  logic [DATA_WIDTH-1:0] step_rem;
  logic                  step_qbit;
  logic [DATA_WIDTH-1:0] step_acc;
  logic [DATA_WIDTH-1:0] new_t;
  logic                  result_load;

  // The modulus divides during reduction, the old remainder during rounds.
  assign step_divisor = (state_q == StReduce) ? mod_q : r1_q;

  miu_step #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_step (
    .rem_i    (rem_q),
    .bit_i    (div_q[DATA_WIDTH-1]),
    .divisor_i(step_divisor),
    .acc_i    (acc_q),
    .qbit_i   (qbit_q),
    .mult_i   (t1_q),
    .mod_i    (mod_q),
    .rem_o    (step_rem),
    .qbit_o   (step_qbit),
    .acc_o    (step_acc)
  );

  // New coefficient t0 - q * t1 modulo m; both operands are below m.
  assign new_t = (t0_q >= acc_q) ? (t0_q - acc_q) : (t0_q + (mod_q - acc_q));

  // A configuration write goes first, so a new item always sees the new modulus.
  assign in_ready_o  = (state_q == StIdle) && !cfg_valid_i;
  assign cfg_ready_o = (state_q == StIdle);
  assign result_load = (state_q == StDone) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d   = state_q;
    r0_d      = r0_q;
    r1_d      = r1_q;
    t0_d      = t0_q;
    t1_d      = t1_q;
    rem_d     = rem_q;
    div_d     = div_q;
    acc_d     = acc_q;
    qbit_d    = qbit_q;
    cnt_d     = cnt_q;
    res_inv_d = res_inv_q;
    res_ok_d  = res_ok_q;

    case (state_q)
      StIdle: begin
        if (in_valid_i && in_ready_o) begin
          if (mod_q < DATA_WIDTH'(2)) begin
            // A modulus of zero or one has no inverses at all.
            res_inv_d = '0;
            res_ok_d  = 1'b0;
            state_d   = StDone;
          end else begin
            div_d   = value_i;
            rem_d   = '0;
            cnt_d   = '0;
            state_d = StReduce;
          end
        end
      end
      StReduce: begin
        rem_d = step_rem;
        div_d = {div_q[DATA_WIDTH-2:0], 1'b0};
        cnt_d = cnt_q + CntWidth'(1);
        if (cnt_q == CntLastBit) begin
          r0_d    = mod_q;
          r1_d    = step_rem;
          t0_d    = '0;
          t1_d    = DATA_WIDTH'(1);
          state_d = StTest;
        end
      end
      StTest: begin
        if (r1_q == '0) begin
          // Euclid is done: r0 is the gcd and t0 the coefficient.
          res_ok_d  = (r0_q == DATA_WIDTH'(1));
          res_inv_d = (r0_q == DATA_WIDTH'(1)) ? t0_q : '0;
          state_d   = StDone;
        end else begin
          div_d   = r0_q;
          rem_d   = '0;
          acc_d   = '0;
          qbit_d  = 1'b0;
          cnt_d   = '0;
          state_d = StDiv;
        end
      end
      StDiv: begin
        // The product works on the registered quotient bit, so it trails the quotient and needs a flush step.
        acc_d  = step_acc;
        cnt_d  = cnt_q + CntWidth'(1);
        if (cnt_q == CntFlush) begin
          qbit_d  = 1'b0;
          state_d = StUpd;
        end else begin
          rem_d  = step_rem;
          div_d  = {div_q[DATA_WIDTH-2:0], 1'b0};
          qbit_d = step_qbit;
        end
      end
      StUpd: begin
        r0_d    = r1_q;
        r1_d    = rem_q;
        t0_d    = t1_q;
        t1_d    = new_t;
        state_d = StTest;
      end
      StDone: begin
        if (result_load) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Output register: loaded from the finished result, cleared on transfer.
  always_comb begin
    out_valid_d   = out_valid_q;
    inverse_d     = inverse_q;
    has_inverse_d = has_inverse_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (result_load) begin
      out_valid_d   = 1'b1;
      inverse_d     = res_inv_q;
      has_inverse_d = res_ok_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      mod_q       <= ModReset;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      if (cfg_valid_i && cfg_ready_o) begin
        mod_q <= cfg_modulus_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    r0_q          <= r0_d;
    r1_q          <= r1_d;
    t0_q          <= t0_d;
    t1_q          <= t1_d;
    rem_q         <= rem_d;
    div_q         <= div_d;
    acc_q         <= acc_d;
    qbit_q        <= qbit_d;
    res_inv_q     <= res_inv_d;
    res_ok_q      <= res_ok_d;
    inverse_q     <= inverse_d;
    has_inverse_q <= has_inverse_d;
  end

  assign out_valid_o   = out_valid_q;
  assign inverse_o     = inverse_q;
  assign has_inverse_o = has_inverse_q;

  // A result without an inverse always carries zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !has_inverse_o) |-> (inverse_o == '0))
    else $error("result without inverse carries a nonzero value");

  // Coefficients stay reduced modulo the modulus while dividing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv) |-> ((t0_q < mod_q) && (t1_q < mod_q)))
    else $error("coefficient left the range below the modulus");

  // The partial remainder stays below the divisor after each step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == StDiv) && (cnt_q != '0)) |-> (rem_q < r1_q))
    else $error("partial remainder not below divisor");

  // An accepted item keeps the block busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken again right after a transfer");

endmodule

### verif/miu_checker.sv
module miu_checker #(
  parameter int unsigned DATA_WIDTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [DATA_WIDTH-1:0] cfg_modulus_i,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [DATA_WIDTH-1:0] value_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [DATA_WIDTH-1:0] inverse_i,
  input  logic                  has_inverse_i,
  output int                    fail_count_o,
  output int                    owed_o,
  output int                    checked_o,
  output int                    coprime_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import miu_pkg::*;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] inverse;
    logic                  has_inverse;
  } inv_result_t;

  inv_result_t           inverse_q[$];
  logic [DATA_WIDTH-1:0] modulus_q;
  int                    fails = 0;
  int                    checked = 0;
  int                    coprime = 0;

  // Extended Euclid with the value's coefficient kept in 0 .. modulus-1.
  function automatic inv_result_t predict_inverse(logic [DATA_WIDTH-1:0] value,
                                                  logic [DATA_WIDTH-1:0] modulus);
    longint unsigned m, rem_a, rem_b, rem_n, coef_a, coef_b, coef_n, quot;
    inv_result_t     res;
    res = '0;
    m   = modulus;
    if (m < 2) return res;
    rem_a  = m;
    rem_b  = value % m;
    coef_a = 0;
    coef_b = 1;
    while (rem_b != 0) begin
      quot   = rem_a / rem_b;
      rem_n  = rem_a - quot * rem_b;
      coef_n = (coef_a + m - ((quot % m) * coef_b) % m) % m;
      rem_a  = rem_b;
      rem_b  = rem_n;
      coef_a = coef_b;
      coef_b = coef_n;
    end
    if (rem_a == 1) begin
      res.inverse     = DATA_WIDTH'(coef_a % m);
      res.has_inverse = 1'b1;
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    inv_result_t want;
    if (!rst_ni) begin
      modulus_q = DATA_WIDTH'(ModResetValue);
      inverse_q.delete();
    end else begin
      // Results are retired before new values are queued in the same cycle.
      if (out_valid_i && out_ready_i) begin
        if (inverse_q.size() == 0) begin
          $error("result with nothing outstanding: inverse %0d, has_inverse %0b",
                 inverse_i, has_inverse_i);
          fails++;
        end else begin
          want = inverse_q.pop_front();
          checked++;
          if (want.has_inverse) coprime++;
          if (inverse_i !== want.inverse) begin
            $error("inverse mismatch: expected %0d, actual %0d", want.inverse, inverse_i);
            fails++;
          end
          if (has_inverse_i !== want.has_inverse) begin
            $error("has_inverse mismatch: expected %0b, actual %0b",
                   want.has_inverse, has_inverse_i);
            fails++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        inverse_q.push_back(predict_inverse(value_i, modulus_q));
      end
      if (cfg_valid_i && cfg_ready_i) begin
        modulus_q = cfg_modulus_i;
      end
    end
    fail_count_o <= fails;
    owed_o       <= inverse_q.size();
    checked_o    <= checked;
    coprime_o    <= coprime;
  end

endmodule

### verif/tb_modular_inverse_unit.sv
module tb_modular_inverse_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DW = 16;
  // Timeout in clock cycles. The slowest legal run (every value at its longest,
  // plus sender gaps and receiver stalls) stays well below this.
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  // Length of the receiver's long hold-off, enough for the block to back up.
  localparam int unsigned HOLD_CYCLES = 1500;
  localparam int unsigned PHASE_ITEMS = 80;

  // All block inputs start at known values and are then driven at rising edges.
  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          cfg_valid_i = 1'b0;
  logic [DW-1:0] cfg_modulus_i = '0;
  logic          in_valid_i = 1'b0;
  logic [DW-1:0] value_i = '0;
  logic          out_ready_i = 1'b0;

  logic          cfg_ready_o;
  logic          in_ready_o;
  logic          out_valid_o;
  logic [DW-1:0] inverse_o;
  logic          has_inverse_o;

  int            fail_count;
  int            owed;
  int            checked;
  int            coprime;
  int unsigned   cycle_count = 0;
  int            settings_written = 0;
  bit            hold_off_req = 1'b0;

  // Values waiting to be offered to the block, in order.
  logic [DW-1:0] value_q[$];

  modular_inverse_unit #(
    .DATA_WIDTH(DW)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_modulus_i (cfg_modulus_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .inverse_o     (inverse_o),
    .has_inverse_o (has_inverse_o)
  );

  // The checker sits beside the block, watches all three channels and reports
  // its failure count and the number of results still owed.
  miu_checker #(
    .DATA_WIDTH(DW)
  ) checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_modulus_i (cfg_modulus_i),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .value_i       (value_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .inverse_i     (inverse_o),
    .has_inverse_i (has_inverse_o),
    .fail_count_o  (fail_count),
    .owed_o        (owed),
    .checked_o     (checked),
    .coprime_o     (coprime)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver. It switches between stretches of steady acceptance, coin-flip
  // stalls and heavy stalls, and does one long hold-off whenever the stimulus
  // asks for it. The hold-off is counted here, independent of the sender.
  initial begin : receiver
    int mode;
    int span;
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        mode = $urandom_range(0, 2);
        span = $urandom_range(5, 200);
        repeat (span) begin
          case (mode)
            0: begin
              out_ready_i <= 1'b1;
            end
            1: begin
              out_ready_i <= 1'($urandom_range(0, 1));
            end
            default: begin
              out_ready_i <= ($urandom_range(0, 3) == 0);
            end
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  // Offers one value and returns at the edge where its transfer happens.
  // Valid is left high so that a following value can go out back to back.
  task automatic send_value(input logic [DW-1:0] val);
    in_valid_i <= 1'b1;
    value_i    <= val;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Sends the queued values in bursts of random length. Gaps are usually
  // short, sometimes absent and sometimes long enough to let the block go
  // idle, so that the next value lands on every phase of the computation.
  // Valid is lowered only where a real gap follows.
  task automatic send_queued();
    int burst;
    int gap;
    while (value_q.size() > 0) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && value_q.size() > 0) begin
        send_value(value_q.pop_front());
        burst--;
      end
      if (value_q.size() == 0) break;
      case ($urandom_range(0, 3))
        0:       gap = 0;
        1, 2:    gap = $urandom_range(1, 20);
        default: gap = $urandom_range(21, 500);
      endcase
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b0;
  endtask

  // Waits until every result owed by the block has been transferred. The
  // first edge is always taken so that a transfer at the current edge shows
  // up in the checker's count.
  task automatic wait_drained();
    do @(posedge clk_i); while (owed != 0);
  endtask

  // Each value yields exactly one result, so once nothing is owed the block
  // is idle and the modulus may be changed.
  task automatic write_modulus(input logic [DW-1:0] m);
    wait_drained();
    cfg_valid_i   <= 1'b1;
    cfg_modulus_i <= m;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    settings_written++;
  endtask

  // Random value shaped for the current modulus: plain random words, small
  // numbers, exact multiples (no inverse), one past a multiple (inverse one),
  // numbers around the modulus itself and values near the top of the range.
  function automatic logic [DW-1:0] pick_value(input int unsigned m);
    int unsigned k;
    if (m < 2) return DW'($urandom_range(0, 65535));
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return DW'($urandom_range(0, 65535));
      4, 5:       return DW'($urandom_range(0, 300));
      6: begin
        k = $urandom_range(0, 65534 / m);
        return DW'(k * m + 1);
      end
      7: begin
        k = $urandom_range(0, 65535 / m);
        return DW'(k * m);
      end
      8:          return DW'(m + $urandom_range(0, 4) - 2);
      default:    return DW'(65535 - $urandom_range(0, 300));
    endcase
  endfunction

  initial begin : stimulus
    int unsigned m;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed values under the reset modulus of 256: zero, one, the
    // modulus and its neighbors, the widest value and alternating patterns.
    value_q = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd255, 16'd256, 16'd257,
                16'hFFFF, 16'h5555, 16'hAAAA};
    send_queued();

    // Largest modulus: the widest value is congruent to zero here.
    write_modulus(16'hFFFF);
    value_q = '{16'd0, 16'd1, 16'hFFFF, 16'hFFFE, 16'd3, 16'h8000};
    send_queued();

    // Smallest working modulus, then the two moduli that never invert.
    write_modulus(16'd2);
    value_q = '{16'd1, 16'hFFFF};
    send_queued();
    write_modulus(16'd0);
    value_q = '{16'd9};
    send_queued();
    write_modulus(16'd1);
    value_q = '{16'd7};
    send_queued();

    // Random phases, each under its own modulus. Twice the receiver is told
    // to hold off for a long stretch while the sender keeps offering values.
    for (int p = 0; p < 11; p++) begin
      case (p)
        0:       m = $urandom_range(2, 65535);
        1:       m = 65521;
        2:       m = $urandom_range(2, 64);
        3:       m = 65535;
        4:       m = $urandom_range(256, 4096);
        5:       m = 3;
        6:       m = $urandom_range(2, 65535);
        7:       m = 1;
        8:       m = 32768;
        9:       m = 256;
        default: m = 0;
      endcase
      write_modulus(DW'(m));
      for (int i = 0; i < ((m < 2) ? 20 : PHASE_ITEMS); i++) begin
        value_q.push_back(pick_value(m));
      end
      if (p == 0 || p == 6) hold_off_req = 1'b1;
      send_queued();
    end

    // Let every result drain, then allow for a late spurious result.
    wait_drained();
    repeat (500) @(posedge clk_i);

    $display("Checked %0d results (%0d with an inverse, %0d without) across %0d modulus writes.",
             checked, coprime, checked - coprime, settings_written);
    $display("Moduli included 0, 1, 2, 3, 256, 32768, 65521, 65535 and random choices.");
    if (fail_count == 0 && owed == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
sv/miu_pkg.sv
sv/miu_step.sv
sv/modular_inverse_unit.sv
verif/miu_checker.sv
verif/tb_modular_inverse_unit.sv
